FILE: rtl/core/ptfe_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ptfe_pkg: shared types and constants of the pixel twinkle fade engine
// Transfer payloads, the per-pixel table entry, register codes and the
// color table.
// ============================================================================
package ptfe_pkg;

  // One input transfer: which pixel, the time and two random words.
  typedef struct packed {
    logic [4:0]  pixel_index;
    logic [31:0] now_ms;
    logic [15:0] rand_off;
    logic [15:0] rand_colour;
  } in_item_t;

  // One result transfer: the pixel and the color to write.
  typedef struct packed {
    logic [4:0] out_pixel;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_item_t;

  // One entry of the pixel table as held in memory.
  typedef struct packed {
    logic        lit_flag;
    logic [31:0] time_mark;
    logic [15:0] dark_time;
    logic [3:0]  colour_index;
    logic [7:0]  last_level;
  } pix_entry_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_MIN_OFF = 2'd0;
  localparam logic [1:0] REG_MAX_OFF = 2'd1;
  localparam logic [1:0] REG_FADE    = 2'd2;

  localparam logic [15:0] MIN_OFF_RESET = 16'd3000;
  localparam logic [15:0] MAX_OFF_RESET = 16'd6000;
  localparam logic [15:0] FADE_RESET    = 16'd6000;

  // Entry value written by the clearing pass: dark, timer at zero.
  localparam pix_entry_t ENTRY_RESET = '{
    lit_flag:     1'b0,
    time_mark:    32'd0,
    dark_time:    16'd3000,
    colour_index: 4'd0,
    last_level:   8'd0
  };

  // Number of brightness steps that are told apart during a fade.
  localparam logic [7:0] LEVEL_STEPS = 8'd200;

  // x / 10 for any 16-bit x equals (x * 52429) >> 19.
  localparam logic [15:0] RECIP_TEN  = 16'd52429;
  localparam int unsigned RECIP_SHIFT = 19;

  // The shared divider produces one quotient bit per cycle.
  localparam int unsigned DIV_STEPS = 16;
  localparam logic [3:0]  DIV_LAST  = 4'(DIV_STEPS - 1);

  // Full color of each table entry; codes past the table read as entry zero.
  function automatic rgb_t colour_lut(input logic [3:0] idx);
    rgb_t c;
    case (idx)
      4'd1:    c = '{r: 8'd64,  g: 8'd255, b: 8'd64};
      4'd2:    c = '{r: 8'd64,  g: 8'd64,  b: 8'd255};
      4'd3:    c = '{r: 8'd255, g: 8'd255, b: 8'd32};
      4'd4:    c = '{r: 8'd255, g: 8'd64,  b: 8'd255};
      4'd5:    c = '{r: 8'd64,  g: 8'd255, b: 8'd255};
      4'd6:    c = '{r: 8'd255, g: 8'd255, b: 8'd255};
      4'd7:    c = '{r: 8'd148, g: 8'd64,  b: 8'd211};
      4'd8:    c = '{r: 8'd75,  g: 8'd64,  b: 8'd130};
      4'd9:    c = '{r: 8'd255, g: 8'd127, b: 8'd64};
      default: c = '{r: 8'd255, g: 8'd128, b: 8'd64};
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/ptfe_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// ptfe_ram: generic single-port-write, single-port-read memory
// One write and one read per cycle; the read data is registered.
// ============================================================================
module ptfe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage array with a registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/pixel_twinkle_fade_engine.sv
`timescale 1ns / 1ps
// ============================================================================
// pixel_twinkle_fade_engine: per-pixel twinkle and fade sequencer
// Keeps a table of pixel states in memory and turns update requests into
// color writes for a LED strip.
// ============================================================================
// Usage:
//   The input channel carries one update request per transfer: a pixel
//   number, the current time in ms and two random words. The output channel
//   carries at most one color write per request. Requests for pixels at or
//   past NUM_PIXELS are dropped.
//   The configuration port holds the dark time limits and the fade time;
//   write it only while the engine is idle.
//   Path from input transfer to result: read, evaluation, then the output
//   register when a dark pixel lights; on to dark write-back when a lit
//   pixel goes dark with an empty dark range, through the divider first
//   otherwise; through the divider, square, scale and fade write-back for
//   a fade step, skipping the divider when it lands at elapsed time zero.
//   A request that causes no result frees the engine at evaluation, or at
//   fade write-back for a fade step. Requests are handled one at a time.
//   A request for a pixel out of range is dropped without leaving idle.
//   After reset a clearing pass writes every table entry, during which no
//   request is taken. Configuration returns to its defaults.
//   A result waits in the output register while the receiver stalls; the
//   next request is still taken, and the engine holds at its evaluation or
//   write-back step until the output register is free.
// ============================================================================
module pixel_twinkle_fade_engine #(
  parameter int unsigned NUM_PIXELS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Request channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ptfe_pkg::in_item_t   in_data_i,
  // Result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ptfe_pkg::out_item_t  out_data_o,
  // Configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  import ptfe_pkg::*;

  localparam int unsigned AW = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
  localparam logic [AW-1:0] CLR_LAST = AW'(NUM_PIXELS - 1);

  // Sequencer states.
  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_READ    = 4'd2;
  localparam logic [3:0] S_EVAL    = 4'd3;
  localparam logic [3:0] S_DIV     = 4'd4;
  localparam logic [3:0] S_SQUARE  = 4'd5;
  localparam logic [3:0] S_SCALE   = 4'd6;
  localparam logic [3:0] S_FADE_WB = 4'd7;
  localparam logic [3:0] S_DARK_WB = 4'd8;

  logic [3:0]    state_q, state_d;
  logic [AW-1:0] clr_q;

  logic [15:0] min_off_q, max_off_q, fade_q;

  in_item_t    item_q;
  pix_entry_t  ent_q;
  logic [31:0] elapsed_q;
  logic [12:0] cq_q;
  logic [15:0] div_r_q, div_d_q, div_v_q;
  logic [3:0]  div_cnt_q;
  logic        div_draw_q;
  logic        q_full_q;
  logic [16:0] f_q;
  logic [7:0]  level_q;
  rgb_t        rgb_q;

  logic        out_valid_q;
  out_item_t   out_q;

  logic        ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  pix_entry_t  ram_wdata, ram_rdata;

  logic        emit;
  out_item_t   emit_item;
  logic        out_free;
  logic        in_accept, in_range;
  logic [10:0] in_idx_ext, item_idx_ext;
  logic [AW-1:0] item_addr;

  logic [31:0] cq_prod;
  logic [15:0] col_ten, col_rem;
  logic [3:0]  col_idx;
  rgb_t        col_full;
  logic        fade_done, span_ok;
  logic [15:0] span, rem;
  logic [16:0] div_t, div_diff;
  logic        div_ge;
  logic [31:0] sq_prod;
  logic [24:0] lvl_prod, r_prod, g_prod, b_prod;
  rgb_t        scale_col;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_off_q <= MIN_OFF_RESET;
      max_off_q <= MAX_OFF_RESET;
      fade_q    <= FADE_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_MIN_OFF: min_off_q <= pwdata[15:0];
        REG_MAX_OFF: max_off_q <= pwdata[15:0];
        REG_FADE:    fade_q    <= pwdata[15:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MIN_OFF: prdata = {16'd0, min_off_q};
      REG_MAX_OFF: prdata = {16'd0, max_off_q};
      REG_FADE:    prdata = {16'd0, fade_q};
      default:     prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pixel table memory
  // --------------------------------------------------------------------------
  ptfe_ram #(
    .WIDTH ($bits(pix_entry_t)),
    .DEPTH (NUM_PIXELS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Request acceptance and table read address.
  assign in_ready_o   = (state_q == S_IDLE);
  assign in_accept    = in_valid_i && in_ready_o;
  assign in_idx_ext   = {6'd0, in_data_i.pixel_index};
  assign in_range     = (in_idx_ext < 11'(NUM_PIXELS));
  assign ram_re       = in_accept && in_range;
  assign ram_raddr    = in_idx_ext[AW-1:0];
  assign item_idx_ext = {6'd0, item_q.pixel_index};
  assign item_addr    = item_idx_ext[AW-1:0];

  // Output register is free when empty or being drained this cycle.
  assign out_free = !out_valid_q || out_ready_i;

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  // Color pick: quotient by ten through the reciprocal, then the remainder.
  assign cq_prod  = 32'(item_q.rand_colour) * 32'(RECIP_TEN);
  assign col_ten  = {cq_q, 3'b000} + {2'b00, cq_q, 1'b0};
  assign col_rem  = item_q.rand_colour - col_ten;
  assign col_idx  = col_rem[3:0];
  assign col_full = colour_lut(col_idx);

  assign fade_done = (elapsed_q >= {16'd0, fade_q});
  assign span_ok   = (max_off_q > min_off_q);
  assign span      = max_off_q - min_off_q;
  assign rem       = fade_q - elapsed_q[15:0];

  // One restoring division step per cycle.
  assign div_t    = {div_r_q, div_d_q[15]};
  assign div_diff = div_t - {1'b0, div_v_q};
  assign div_ge   = (div_t >= {1'b0, div_v_q});

  // Squared factor and the scaled level and channels.
  assign sq_prod   = 32'(div_d_q) * 32'(div_d_q);
  assign scale_col = colour_lut(ent_q.colour_index);
  assign lvl_prod  = 25'(LEVEL_STEPS) * 25'(f_q);
  assign r_prod    = 25'(scale_col.r) * 25'(f_q);
  assign g_prod    = 25'(scale_col.g) * 25'(f_q);
  assign b_prod    = 25'(scale_col.b) * 25'(f_q);

  // --------------------------------------------------------------------------
  // Sequencer: next state, table write-back and result issue
  // --------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    ram_we    = 1'b0;
    ram_waddr = item_addr;
    ram_wdata = ent_q;
    emit      = 1'b0;
    emit_item = '{out_pixel: item_q.pixel_index, red: 8'd0, green: 8'd0, blue: 8'd0};
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = ENTRY_RESET;
        if (clr_q == CLR_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept && in_range) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (!ent_q.lit_flag) begin
          // Dark pixel lights once its dark time is strictly exceeded.
          if (elapsed_q > {16'd0, ent_q.dark_time}) begin
            if (out_free) begin
              ram_we                 = 1'b1;
              ram_wdata.lit_flag     = 1'b1;
              ram_wdata.time_mark    = item_q.now_ms;
              ram_wdata.colour_index = col_idx;
              ram_wdata.last_level   = 8'd0;
              emit                   = 1'b1;
              emit_item.red          = col_full.r;
              emit_item.green        = col_full.g;
              emit_item.blue         = col_full.b;
              state_d                = S_IDLE;
            end
          end else begin
            state_d = S_IDLE;
          end
        end else if (fade_done) begin
          state_d = span_ok ? S_DIV : S_DARK_WB;
        end else begin
          state_d = (elapsed_q[15:0] == 16'd0) ? S_SQUARE : S_DIV;
        end
      end
      S_DIV: begin
        if (div_cnt_q == DIV_LAST) begin
          state_d = div_draw_q ? S_DARK_WB : S_SQUARE;
        end
      end
      S_SQUARE: begin
        state_d = S_SCALE;
      end
      S_SCALE: begin
        state_d = S_FADE_WB;
      end
      S_FADE_WB: begin
        // A fade step reports only when the coarse level moves.
        if (level_q != ent_q.last_level) begin
          if (out_free) begin
            ram_we               = 1'b1;
            ram_wdata.last_level = level_q;
            emit                 = 1'b1;
            emit_item.red        = rgb_q.r;
            emit_item.green      = rgb_q.g;
            emit_item.blue       = rgb_q.b;
            state_d              = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DARK_WB: begin
        // Fade over: go dark, drawn dark time or the minimum on an empty span.
        if (out_free) begin
          ram_we               = 1'b1;
          ram_wdata.lit_flag   = 1'b0;
          ram_wdata.time_mark  = item_q.now_ms;
          ram_wdata.dark_time  = min_off_q + div_r_q;
          ram_wdata.last_level = 8'd0;
          emit                 = 1'b1;
          state_d              = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
    end
  end

  // Datapath registers, loaded by sequencer step.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          item_q <= in_data_i;
        end
      end
      S_READ: begin
        ent_q     <= ram_rdata;
        elapsed_q <= item_q.now_ms - ram_rdata.time_mark;
        cq_q      <= cq_prod[RECIP_SHIFT +: 13];
      end
      S_EVAL: begin
        div_cnt_q <= '0;
        q_full_q  <= (elapsed_q[15:0] == 16'd0);
        if (fade_done) begin
          // Remainder of rand_off by the dark time span.
          div_draw_q <= 1'b1;
          div_r_q    <= 16'd0;
          div_d_q    <= item_q.rand_off;
          div_v_q    <= span;
        end else begin
          // Quotient of (rem << 16) by the fade time, rem below fade.
          div_draw_q <= 1'b0;
          div_r_q    <= rem;
          div_d_q    <= 16'd0;
          div_v_q    <= fade_q;
        end
      end
      S_DIV: begin
        div_r_q   <= div_ge ? div_diff[15:0] : div_t[15:0];
        div_d_q   <= {div_d_q[14:0], div_ge};
        div_cnt_q <= div_cnt_q + 4'd1;
      end
      S_SQUARE: begin
        f_q <= q_full_q ? 17'h10000 : {1'b0, sq_prod[31:16]};
      end
      S_SCALE: begin
        level_q <= lvl_prod[23:16];
        rgb_q   <= '{r: r_prod[23:16], g: g_prod[23:16], b: b_prod[23:16]};
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= emit_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  // The table is never read and written in the same cycle.
  a_no_ram_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("table read and write in the same cycle");

  // A waiting result is never overwritten by a new one.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !emit)
    else $error("result issued while the output register is held");

  // The divider leaves after its last step toward square or dark write-back.
  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && div_cnt_q == DIV_LAST) |=>
      (state_q == S_SQUARE || state_q == S_DARK_WB))
    else $error("divider did not finish in sixteen steps");

  // The fade level never passes the step count.
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FADE_WB) |-> (level_q <= LEVEL_STEPS))
    else $error("fade level out of range");
`endif

endmodule
